FILE: sv/ise_pkg.sv
// Shared types and constants for the integer sort engine.
// Used by ise_cell and integer_sort_engine; no dependencies.
package ise_pkg;

  localparam int MaxItems = 64;
  localparam int CountW   = $clog2(MaxItems + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic               overflow;
  } out_req_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } slot_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'b001,
    OP_INSERT = 3'b010,
    OP_SHIFT  = 3'b100
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } state_e;

endpackage

FILE: sv/ise_cell.sv
// One cell of the systolic insertion chain: a stored slot and a carry slot.
// Depends on ise_pkg.
module ise_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ise_pkg::cell_op_e op_i,
  input  ise_pkg::slot_t   left_i,
  input  ise_pkg::slot_t   right_i,
  output ise_pkg::slot_t   stored_o,
  output ise_pkg::slot_t   pass_o
);
  import ise_pkg::*;

  slot_t stored_q, stored_d;
  slot_t carry_q, carry_d;

  always_comb begin
    stored_d = stored_q;
    carry_d  = carry_q;
    pass_o   = '0;
    case (op_i)
      OP_INSERT: begin
        carry_d = left_i;
        if (carry_q.valid) begin
          if (!stored_q.valid) begin
            stored_d = carry_q;
          end else if (carry_q.value < stored_q.value) begin
            stored_d = carry_q;
            pass_o   = stored_q;
          end else begin
            pass_o = carry_q;
          end
        end
      end
      OP_SHIFT: begin
        stored_d = right_i;
        carry_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      carry_q  <= '0;
    end else begin
      stored_q <= stored_d;
      carry_q  <= carry_d;
    end
  end

  assign stored_o = stored_q;

endmodule

FILE: sv/integer_sort_engine.sv
// Integer sort engine: values load one per cycle into a chain of MaxItems cells.
// After the last request the chain settles until its timer runs out, then drains one
// result per cycle from cell 0 while out_stall_i is low.
// Input stays stalled from the last request until the final result is taken.
// Reset empties the chain and clears the item count and overflow flag.
module integer_sort_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ise_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ise_pkg::out_req_t out_req_o
);
  import ise_pkg::*;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   timer_q, timer_d;
  logic                dropped_q, dropped_d;
  cell_op_e            op;
  slot_t               entry;
  slot_t               stored [MaxItems];
  slot_t               pass   [MaxItems];
  logic                in_acc, out_acc, has_room;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_DRAIN);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign has_room    = (count_q < CountW'(MaxItems));

  assign entry.valid = in_acc && has_room;
  assign entry.value = in_req_i.value;

  always_comb begin
    op = OP_HOLD;
    case (state_q)
      ST_LOAD, ST_SETTLE: op = OP_INSERT;
      ST_DRAIN: op = out_acc ? OP_SHIFT : OP_HOLD;
      default: op = OP_HOLD;
    endcase
  end

  for (genvar g = 0; g < MaxItems; g++) begin : g_cell
    slot_t left, right;
    if (g == 0) begin : g_first
      assign left = entry;
    end else begin : g_mid
      assign left = pass[g-1];
    end
    if (g == MaxItems - 1) begin : g_end
      assign right = '0;
    end else begin : g_inner
      assign right = stored[g+1];
    end
    ise_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (op),
      .left_i   (left),
      .right_i  (right),
      .stored_o (stored[g]),
      .pass_o   (pass[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    timer_d   = timer_q;
    dropped_d = dropped_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + CountW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_req_i.last) begin
            state_d = ST_SETTLE;
            timer_d = CountW'(MaxItems);
          end
        end
      end
      ST_SETTLE: begin
        timer_d = timer_q - CountW'(1);
        if (timer_q == CountW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_d = count_q - CountW'(1);
          if (count_q == CountW'(1)) begin
            state_d   = ST_LOAD;
            dropped_d = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      timer_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      timer_q   <= timer_d;
      dropped_q <= dropped_d;
    end
  end

  assign out_req_o.value_res = stored[0].value;
  assign out_req_o.last_res  = (count_q == CountW'(1));
  assign out_req_o.overflow  = dropped_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stored[0].valid)
    else $error("result requested from an empty head cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxItems))
    else $error("item count exceeds capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_req_o.last_res) |=> (state_q == ST_LOAD && count_q == '0 && !dropped_q))
    else $error("set did not close after its final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_q != '0)
    else $error("draining with no stored values");

endmodule
